[rtl/core/fpl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the frame pacing limiter.
// No dependencies; every other file of the block refers to this package.
package fpl_pkg;

    localparam int WINDOW_DEF = 32;

    localparam int TICK_W  = 32;
    localparam int FT_W    = 32;
    localparam int RATE_W  = 23;
    localparam int SLEEP_W = 10;
    localparam int LIMIT_W = 10;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 72;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int SCALE_W    = 18;
    localparam int RATE_SCALE = 256000;
    localparam int SLEEP_NUM  = 1000;

    localparam logic [RATE_W-1:0] RATE_MAX  = 23'h7FFFFF;
    localparam logic [RATE_W-1:0] IDLE_RATE = 23'(999 * 256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FPS        = 2'd0,
        CFG_LIMITER_ENABLE = 2'd1,
        CFG_CALC_MODE      = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_PREV,
        ST_RD_OLD,
        ST_RATE_LOAD,
        ST_RATE_DIV,
        ST_BASE_LOAD,
        ST_BASE_DIV,
        ST_COMP_DONE
    } fpl_state_t;

endpackage

[rtl/core/fpl_stamp_ring.sv]
`timescale 1ns / 1ps
// Timestamp ring memory: one write port and one registered read port.
// Depends on fpl_pkg for the timestamp width.
module fpl_stamp_ring #(
    parameter int DEPTH  = fpl_pkg::WINDOW_DEF + 1,
    parameter int ADDR_W = $clog2(fpl_pkg::WINDOW_DEF + 1)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [fpl_pkg::TICK_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [fpl_pkg::TICK_W-1:0] rd_data
);

    logic [fpl_pkg::TICK_W-1:0] mem [DEPTH];
    logic [fpl_pkg::TICK_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/fpl_serial_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle, shared by the
// rate and sleep calculations. Depends on fpl_pkg for the divisor width.
module fpl_serial_div #(
    parameter int DIV_W = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DIV_W-1:0]           dividend,
    input  logic [fpl_pkg::TICK_W-1:0] divisor,
    output logic                       done,
    output logic [DIV_W-1:0]           quotient
);

    localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [fpl_pkg::TICK_W-1:0] rem_reg, rem_next;
    logic [fpl_pkg::TICK_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W-1:0]           quo_reg, quo_next;
    logic [fpl_pkg::TICK_W:0]   trial;
    logic [fpl_pkg::TICK_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (!diff[fpl_pkg::TICK_W]) begin
                rem_next = diff[fpl_pkg::TICK_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[fpl_pkg::TICK_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/frame_pacing_limiter.sv]
`timescale 1ns / 1ps
// Frame pacing limiter: an accepted frame reads its previous and oldest stamps, runs a rate
// division and, with a limit latched, a base sleep division on the shared bit-serial divider
// (one bit a cycle, DIV_W = $clog2(WINDOW+1)+18), then registers its result; no new frame is
// taken before that. With the limiter disabled a frame goes from idle to the result state.
// Synchronous active-low reset clears the control state and config; data registers are not.
module frame_pacing_limiter #(
    parameter int WINDOW = fpl_pkg::WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fpl_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] tick_ms
    input  logic                           s_tuser,   // [0] foreground
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpl_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] frame_time_ms,
                                                      // [54:32] fps_q8,
                                                      // [64:55] sleep_ms, [71:65] zero
    output logic                           m_tuser,   // [0] window_restart
    input  logic                           cfg_wr_en,
    input  logic [fpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W  = $clog2(WINDOW + 1);
    localparam int DEPTH   = WINDOW + 1;
    localparam int DIV_W   = SLOT_W + fpl_pkg::SCALE_W;
    localparam int Q_EXT_W = (DIV_W > fpl_pkg::RATE_W) ? DIV_W : fpl_pkg::RATE_W;
    localparam logic [SLOT_W-1:0] WIN_LAST = SLOT_W'(WINDOW);
    localparam logic [DIV_W-1:0]  SCALE    = DIV_W'(fpl_pkg::RATE_SCALE);
    localparam logic [DIV_W-1:0]  SLEEP_DV = DIV_W'(fpl_pkg::SLEEP_NUM);
    localparam int PAD_W = fpl_pkg::M_TDATA_W - fpl_pkg::FT_W - fpl_pkg::RATE_W
                           - fpl_pkg::SLEEP_W;

    fpl_pkg::fpl_state_t state_reg, state_next;

    logic [fpl_pkg::LIMIT_W-1:0] max_fps_reg;
    logic                        limiter_enable_reg;
    logic                        calc_mode_reg;

    logic [SLOT_W-1:0]           write_slot_reg;
    logic                        ring_full_reg;
    logic [fpl_pkg::LIMIT_W-1:0] latched_limit_reg;
    logic [fpl_pkg::SLEEP_W-1:0] prior_sleep_reg;
    logic [fpl_pkg::FT_W-1:0]    held_ft_reg;
    logic [fpl_pkg::RATE_W-1:0]  held_rate_reg;

    logic [fpl_pkg::TICK_W-1:0]  now_reg;
    logic                        elapsed_zero_reg;
    logic [fpl_pkg::SLEEP_W-1:0] base_reg;
    logic [fpl_pkg::SLEEP_W-1:0] res_sleep_reg;
    logic                        res_restart_reg;

    logic                        m_valid_reg;
    logic [fpl_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                        m_user_reg;

    logic                        in_accept;
    logic                        out_free;
    logic                        first_empty;

    logic                        ring_wr_pending;
    logic                        ring_wr_en;
    logic [SLOT_W-1:0]           ring_wr_addr;
    logic [SLOT_W-1:0]           ring_rd_addr;
    logic [fpl_pkg::TICK_W-1:0]  ring_rd_data;

    logic                        div_start;
    logic [DIV_W-1:0]            div_dividend;
    logic [fpl_pkg::TICK_W-1:0]  div_divisor;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quotient;

    logic [SLOT_W-1:0]           frames;
    logic [fpl_pkg::TICK_W-1:0]  stamp_diff;
    logic [Q_EXT_W-1:0]          q_ext;
    logic [fpl_pkg::RATE_W-1:0]  rate_sat;
    logic [fpl_pkg::TICK_W-1:0]  comp_w;
    logic [fpl_pkg::TICK_W-1:0]  comp_cap;
    logic [fpl_pkg::SLEEP_W-1:0] sleep_val;
    logic                        restart_val;

    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign first_empty = !ring_full_reg && (write_slot_reg == '0);
    assign frames      = ring_full_reg ? WIN_LAST : write_slot_reg;
    assign stamp_diff  = now_reg - ring_rd_data;
    assign q_ext       = Q_EXT_W'(div_quotient);
    assign rate_sat    = (q_ext > Q_EXT_W'(fpl_pkg::RATE_MAX)) ? fpl_pkg::RATE_MAX
                                                               : q_ext[fpl_pkg::RATE_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fpl_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = limiter_enable_reg ? fpl_pkg::ST_RD_PREV
                                                    : fpl_pkg::ST_COMP_DONE;
                end
            end
            fpl_pkg::ST_RD_PREV:   state_next = fpl_pkg::ST_RD_OLD;
            fpl_pkg::ST_RD_OLD:    state_next = fpl_pkg::ST_RATE_LOAD;
            fpl_pkg::ST_RATE_LOAD: state_next = fpl_pkg::ST_RATE_DIV;
            fpl_pkg::ST_RATE_DIV: begin
                if (div_done) begin
                    state_next = (latched_limit_reg != '0) ? fpl_pkg::ST_BASE_LOAD
                                                           : fpl_pkg::ST_COMP_DONE;
                end
            end
            fpl_pkg::ST_BASE_LOAD: state_next = fpl_pkg::ST_BASE_DIV;
            fpl_pkg::ST_BASE_DIV: begin
                if (div_done) begin
                    state_next = fpl_pkg::ST_COMP_DONE;
                end
            end
            fpl_pkg::ST_COMP_DONE: begin
                if (out_free) begin
                    state_next = fpl_pkg::ST_IDLE;
                end
            end
            default: state_next = fpl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        ring_rd_addr = '0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(frames) * SCALE;
        div_divisor  = stamp_diff;
        case (state_reg)
            fpl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            fpl_pkg::ST_RD_PREV: begin
                ring_rd_addr = (write_slot_reg == '0) ? WIN_LAST : write_slot_reg - 1'b1;
            end
            fpl_pkg::ST_RD_OLD: begin
                if (ring_full_reg) begin
                    ring_rd_addr = (write_slot_reg == WIN_LAST) ? '0 : write_slot_reg + 1'b1;
                end
            end
            fpl_pkg::ST_RATE_LOAD: begin
                div_start = 1'b1;
            end
            fpl_pkg::ST_BASE_LOAD: begin
                div_start    = 1'b1;
                div_dividend = SLEEP_DV;
                div_divisor  = fpl_pkg::TICK_W'(latched_limit_reg);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        comp_w      = fpl_pkg::TICK_W'(base_reg)
                      - (held_ft_reg - fpl_pkg::TICK_W'(prior_sleep_reg));
        comp_cap    = ($signed(comp_w) > $signed(fpl_pkg::TICK_W'(base_reg)))
                      ? fpl_pkg::TICK_W'(base_reg) : comp_w;
        sleep_val   = '0;
        restart_val = 1'b0;
        if (latched_limit_reg != '0) begin
            if (!calc_mode_reg) begin
                sleep_val = base_reg;
            end else if ($signed(comp_cap) < $signed(fpl_pkg::TICK_W'(1))) begin
                restart_val = 1'b1;
            end else begin
                sleep_val = comp_cap[fpl_pkg::SLEEP_W-1:0];
            end
        end
    end

    // The ring takes the new stamp once per enabled frame, at entry 0 on a restart.
    assign ring_wr_en   = (state_reg == fpl_pkg::ST_COMP_DONE) && ring_wr_pending;
    assign ring_wr_addr = restart_val ? '0 : write_slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_wr_pending <= 1'b0;
        end else if (state_reg == fpl_pkg::ST_COMP_DONE) begin
            ring_wr_pending <= 1'b0;
        end else if (state_next == fpl_pkg::ST_COMP_DONE && state_reg != fpl_pkg::ST_IDLE) begin
            ring_wr_pending <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= fpl_pkg::ST_IDLE;
            max_fps_reg        <= '0;
            limiter_enable_reg <= 1'b0;
            calc_mode_reg      <= 1'b1;
            write_slot_reg     <= '0;
            ring_full_reg      <= 1'b0;
            latched_limit_reg  <= '0;
            prior_sleep_reg    <= '0;
            held_ft_reg        <= '0;
            held_rate_reg      <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    fpl_pkg::CFG_MAX_FPS:        max_fps_reg        <= cfg_data;
                    fpl_pkg::CFG_LIMITER_ENABLE: limiter_enable_reg <= cfg_data[0];
                    fpl_pkg::CFG_CALC_MODE:      calc_mode_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_accept && limiter_enable_reg && s_tuser) begin
                latched_limit_reg <= max_fps_reg;
            end
            if (state_reg == fpl_pkg::ST_RD_OLD) begin
                held_ft_reg <= first_empty ? '0 : stamp_diff;
            end
            if (state_reg == fpl_pkg::ST_RATE_DIV && div_done) begin
                held_rate_reg <= elapsed_zero_reg ? fpl_pkg::IDLE_RATE : rate_sat;
            end
            if (ring_wr_en) begin
                if (restart_val) begin
                    write_slot_reg <= SLOT_W'(1);
                    ring_full_reg  <= 1'b0;
                end else if (write_slot_reg == WIN_LAST) begin
                    write_slot_reg <= '0;
                    ring_full_reg  <= 1'b1;
                end else begin
                    write_slot_reg <= write_slot_reg + 1'b1;
                end
                if (latched_limit_reg != '0) begin
                    prior_sleep_reg <= sleep_val;
                end
            end
            if (state_reg == fpl_pkg::ST_COMP_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            now_reg         <= s_tdata[fpl_pkg::TICK_W-1:0];
            res_sleep_reg   <= '0;
            res_restart_reg <= 1'b0;
        end
        if (state_reg == fpl_pkg::ST_RATE_LOAD) begin
            elapsed_zero_reg <= first_empty || (stamp_diff == '0);
        end
        if (state_reg == fpl_pkg::ST_BASE_DIV && div_done) begin
            base_reg <= div_quotient[fpl_pkg::SLEEP_W-1:0];
        end
        if (ring_wr_en) begin
            res_sleep_reg   <= sleep_val;
            res_restart_reg <= restart_val;
        end
        if (state_reg == fpl_pkg::ST_COMP_DONE && out_free) begin
            if (ring_wr_en) begin
                m_data_reg <= {PAD_W'(0), sleep_val, held_rate_reg, held_ft_reg};
                m_user_reg <= restart_val;
            end else begin
                m_data_reg <= {PAD_W'(0), res_sleep_reg, held_rate_reg, held_ft_reg};
                m_user_reg <= res_restart_reg;
            end
        end
    end

    fpl_stamp_ring #(
        .DEPTH  (DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (now_reg),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    fpl_serial_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[rtl/core/fpl_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the frame pacing limiter, bound to the top level.
// Depends on fpl_pkg for the port widths.
module fpl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fpl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result transfer changed while stalled.");

    a_restart_no_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[64:55] == 10'd0)
        else $error("A window restart came with a non-zero sleep.");

    a_sleep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[64:55] <= 10'd1000)
        else $error("Sleep time exceeds one second.");

    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> s_tready && !m_tvalid)
        else $error("Block not idle after reset.");

endmodule

bind frame_pacing_limiter fpl_checker u_fpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for frame_pacing_limiter: frame timestamps are sent, and every result
// is compared with a local model of the window, the frame rate and the sleep compensation.
// Depends on fpl_pkg and the frame_pacing_limiter RTL only.
module tb_top;
    import fpl_pkg::*;

    localparam int WIN            = WINDOW_DEF;
    localparam int LIMIT_CYCLES   = 1500000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 64;
    localparam int HOLDOFF_CYCLES = 800;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [FT_W-1:0]    frame_time;
        logic [RATE_W-1:0]  rate;
        logic [SLEEP_W-1:0] sleep;
        logic               restart;
    } pacing_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [M_TDATA_W-1:0]   m_tdata;
    wire                   m_tuser;

    frame_pacing_limiter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Model state, mirroring the block after reset.
    logic [TICK_W-1:0]  stamp_hist [0:WIN];
    int unsigned        next_slot       = 0;
    bit                 hist_full       = 1'b0;
    logic [LIMIT_W-1:0] pace_limit      = '0;
    logic [SLEEP_W-1:0] pace_prior      = '0;
    logic [FT_W-1:0]    last_frame_time = '0;
    logic [RATE_W-1:0]  last_rate       = '0;
    logic [LIMIT_W-1:0] reg_max_fps     = '0;
    bit                 reg_enable      = 1'b0;
    bit                 reg_calc        = 1'b1;

    pacing_result_t awaited_results [$];
    pacing_result_t got_result;
    pacing_result_t want_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_seq    = 0;
    int holdoff_seen   = 0;
    int holdoff_left   = 0;
    int cycle_count    = 0;
    int fail_count     = 0;
    int frames_sent    = 0;
    int restarts_seen  = 0;
    int settings_used  = 0;

    function automatic pacing_result_t predict_frame(input logic [TICK_W-1:0] now, input bit fg);
        pacing_result_t res;
        int unsigned    slot;
        int unsigned    oldest;
        int unsigned    frames;
        logic [31:0]    elapsed;
        logic [31:0]    base;
        logic [31:0]    wrapped;
        int             signed_sleep;
        longint unsigned quot;
        res = '0;
        if (!reg_enable) begin
            res.frame_time = last_frame_time;
            res.rate       = last_rate;
            return res;
        end
        slot = next_slot;
        stamp_hist[slot] = now;
        oldest = 0;
        frames = slot;
        if (hist_full) begin
            oldest = (slot == WIN) ? 0 : slot + 1;
            frames = WIN;
        end
        if (slot == 0) begin
            last_frame_time = hist_full ? now - stamp_hist[WIN] : '0;
        end else begin
            last_frame_time = now - stamp_hist[slot-1];
        end
        elapsed = now - stamp_hist[oldest];
        if (elapsed == 0) begin
            last_rate = IDLE_RATE;
        end else begin
            quot = (64'(frames) * 64'(RATE_SCALE)) / 64'(elapsed);
            last_rate = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
        end
        if (slot == WIN) begin
            next_slot = 0;
            hist_full = 1'b1;
        end else begin
            next_slot = slot + 1;
        end
        if (fg) begin
            pace_limit = reg_max_fps;
        end
        res.frame_time = last_frame_time;
        res.rate       = last_rate;
        if (pace_limit != 0) begin
            base = 32'(SLEEP_NUM) / 32'(pace_limit);
            res.sleep = base[SLEEP_W-1:0];
            if (reg_calc) begin
                wrapped = base - (last_frame_time - 32'(pace_prior));
                signed_sleep = $signed(wrapped);
                if (signed_sleep > int'(base)) begin
                    signed_sleep = int'(base);
                end
                if (signed_sleep < 1) begin
                    signed_sleep  = 0;
                    next_slot     = 1;
                    stamp_hist[0] = now;
                    hist_full     = 1'b0;
                    res.restart   = 1'b1;
                end
                res.sleep = signed_sleep[SLEEP_W-1:0];
            end
            pace_prior = res.sleep;
        end
        return res;
    endfunction

    task automatic send_frame(input logic [TICK_W-1:0] tick, input bit fg);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 64);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tick;
        s_tuser  <= fg;
        do @(posedge aclk); while (!s_tready);
        awaited_results.push_back(predict_frame(tick, fg));
        frames_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    task automatic set_config(input logic [LIMIT_W-1:0] fps, input bit en, input bit calc);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_FPS;
        cfg_data  <= fps;
        @(posedge aclk);
        cfg_index <= CFG_LIMITER_ENABLE;
        cfg_data  <= CFG_DATA_W'(en);
        @(posedge aclk);
        cfg_index <= CFG_CALC_MODE;
        cfg_data  <= CFG_DATA_W'(calc);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_max_fps = fps;
        reg_enable  = en;
        reg_calc    = calc;
        settings_used++;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 48;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 48;
            end
            default: begin
                send_idle_pct  = 32;
                recv_stall_pct = 32;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("tb_top: %s at cycle %0d", what, cycle_count);
            $display("    expected ft=%0d fps_q8=%0d sleep=%0d restart=%0d",
                     want_result.frame_time, want_result.rate, want_result.sleep,
                     want_result.restart);
            $display("    actual   ft=%0d fps_q8=%0d sleep=%0d restart=%0d",
                     got_result.frame_time, got_result.rate, got_result.sleep,
                     got_result.restart);
        end
    endtask

    // Limiter still disabled from reset: frames are ignored and held values are zero.
    task automatic test_disabled_at_reset();
        send_frame(32'hFFFF_FFFF, 1'b1);
        send_frame(32'h0000_0000, 1'b0);
    endtask

    // Fixed sleep, the limit only latching in foreground, a repeated stamp and a counter wrap.
    task automatic test_fixed_sleep();
        set_config(10'd1000, 1'b1, 1'b0);
        send_frame(32'hFFFF_FFF0, 1'b0);
        send_frame(32'hFFFF_FFF0, 1'b1);
        send_frame(32'h0000_0005, 1'b1);
        send_frame(32'h8000_0000, 1'b0);
    endtask

    // Compensated sleep at the lowest limit: capping at the base, shortening and restart.
    task automatic test_compensated_sleep();
        set_config(10'd1, 1'b1, 1'b1);
        send_frame(32'd100, 1'b1);
        send_frame(32'd100, 1'b1);
        send_frame(32'd400, 1'b1);
        send_frame(32'd1500, 1'b1);
        send_frame(32'd9000, 1'b1);
    endtask

    // A zero limit stops pacing, but only once a foreground frame latches it.
    task automatic test_pacing_off();
        set_config(10'd0, 1'b1, 1'b1);
        send_frame(32'd9010, 1'b0);
        send_frame(32'd9020, 1'b1);
        send_frame(32'd9020, 1'b1);
    endtask

    // Limits above 1000 give a base of zero in both sleep modes.
    task automatic test_limit_beyond_range();
        set_config(10'd1023, 1'b1, 1'b1);
        send_frame(32'd9030, 1'b1);
        send_frame(32'd9031, 1'b0);
        set_config(10'd1023, 1'b1, 1'b0);
        send_frame(32'd9040, 1'b1);
        send_frame(32'd9050, 1'b1);
    endtask

    // Disabling the limiter again holds the last frame time and rate.
    task automatic test_disabled_hold();
        set_config(10'd500, 1'b0, 1'b1);
        send_frame(32'h7FFF_FFFF, 1'b1);
        send_frame(32'h1234_5678, 1'b0);
    endtask

    // Mostly paced frame sequences with random work time, plus bursts, jumps and steps back.
    task automatic test_random_frames();
        int                 p;
        int                 n;
        int                 items;
        int unsigned        r;
        int unsigned        work_max;
        logic [LIMIT_W-1:0] fps;
        bit                 en;
        bit                 calc;
        logic [TICK_W-1:0]  tick;
        for (p = 0; p < 16; p++) begin
            case (p)
                0: fps = 10'd1000;
                1: fps = 10'd1;
                2: fps = 10'd60;
                3: fps = 10'd0;
                4: fps = 10'd1023;
                5: fps = 10'd144;
                6: fps = 10'd30;
                7: fps = 10'd500;
                default: fps = LIMIT_W'($urandom_range(1, 1023));
            endcase
            en   = (p != 5) && (p != 11);
            calc = (p % 3) != 2;
            set_config(fps, en, calc);
            set_idle(p % 4);
            items = en ? 118 : 15;
            tick  = (p % 4 == 1) ? 32'hFFFF_FF00 : $urandom();
            if (fps == 0 || fps > 1000) begin
                work_max = 20;
            end else begin
                work_max = 1000 / fps + 1000 / fps / 4 + 1;
            end
            for (n = 0; n < items; n++) begin
                r = $urandom_range(99);
                if (r < 80) begin
                    tick += 32'(pace_prior) + $urandom_range(0, work_max);
                end else if (r < 90) begin
                    tick += $urandom_range(0, 3);
                end else if (r < 95) begin
                    tick += $urandom();
                end else begin
                    tick -= $urandom_range(1, 50);
                end
                send_frame(tick, $urandom_range(99) < 85);
            end
        end
        set_idle(0);
    endtask

    // The receiver holds off while frames keep coming, then the sender waits for every result.
    task automatic test_backpressure();
        int                n;
        logic [TICK_W-1:0] tick;
        set_config(10'd60, 1'b1, 1'b1);
        set_idle(0);
        tick = $urandom();
        holdoff_seq++;
        for (n = 0; n < 12; n++) begin
            tick += 16 + $urandom_range(0, 4);
            send_frame(tick, 1'b1);
        end
        drain_results();
        for (n = 0; n < 6; n++) begin
            tick += 16 + $urandom_range(0, 30);
            send_frame(tick, 1'b1);
        end
    endtask

    always @(posedge aclk) begin
        if (holdoff_seq != holdoff_seen) begin
            holdoff_seen = holdoff_seq;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.frame_time = m_tdata[FT_W-1:0];
            got_result.rate       = m_tdata[FT_W +: RATE_W];
            got_result.sleep      = m_tdata[FT_W+RATE_W +: SLEEP_W];
            got_result.restart    = m_tuser;
            if (got_result.restart) begin
                restarts_seen++;
            end
            if (awaited_results.size() == 0) begin
                want_result = '0;
                report_mismatch("result transfer with nothing expected");
            end else begin
                want_result = awaited_results.pop_front();
                if (got_result.frame_time !== want_result.frame_time ||
                    got_result.rate !== want_result.rate ||
                    got_result.sleep !== want_result.sleep ||
                    got_result.restart !== want_result.restart) begin
                    report_mismatch("result mismatch");
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_top: timed out after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_at_reset();
        test_fixed_sleep();
        test_compensated_sleep();
        test_pacing_off();
        test_limit_beyond_range();
        test_disabled_hold();
        test_random_frames();
        test_backpressure();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            fail_count++;
        end
        $display("tb_top: %0d frames under %0d register settings, %0d window restarts seen,",
                 frames_sent, settings_used, restarts_seen);
        $display("tb_top: stalls on both sides and one long hold-off; %0d failures", fail_count);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
